// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the save controller checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== sv/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, command constants and address helpers of the save controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SRAM,
		KIND_FLASH64,
		KIND_FLASH128
	} kind_e;

	typedef enum logic [1:0] {
		STAGE_IDLE,
		STAGE_ONE,
		STAGE_TWO,
		STAGE_UNUSED
	} stage_e;

	typedef enum logic [2:0] {
		OP_RD_CONST,
		OP_RD_MEM,
		OP_WR_MEM,
		OP_PROG,
		OP_ERASE_CHIP,
		OP_ERASE_SECT
	} op_e;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_PROG,
		BK_SWEEP,
		BK_SECTOR
	} bk_state_e;

	localparam int ADDR_BITS   = 17;
	localparam int SECTOR_BITS = 12;

	typedef struct packed {
		op_e                   op;
		logic [ADDR_BITS-1:0]  addr;
		logic [7:0]            data;
		kind_e                 kind;
	} q_entry_t;

	localparam logic [15:0] ADDR_UNLOCK_A = 16'h5555;
	localparam logic [15:0] ADDR_UNLOCK_B = 16'h2AAA;
	localparam logic [7:0]  KEY_A         = 8'hAA;
	localparam logic [7:0]  KEY_B         = 8'h55;
	localparam logic [7:0]  CMD_ID_ON     = 8'h90;
	localparam logic [7:0]  CMD_ID_OFF    = 8'hF0;
	localparam logic [7:0]  CMD_ERASE     = 8'h80;
	localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
	localparam logic [7:0]  CMD_BANK      = 8'hB0;
	localparam logic [7:0]  CMD_CHIP_ERS  = 8'h10;
	localparam logic [7:0]  CMD_SECT_ERS  = 8'h30;
	localparam logic [7:0]  ID128_MAKER   = 8'hC2;
	localparam logic [7:0]  ID128_DEVICE  = 8'h09;
	localparam logic [7:0]  ID64_MAKER    = 8'h32;
	localparam logic [7:0]  ID64_DEVICE   = 8'h1B;
	localparam logic [7:0]  BYTE_ERASED   = 8'hFF;

	// Wraps a bank-extended address into the active size of the chip.
	function automatic logic [ADDR_BITS-1:0] fsc_reduce(
		input logic [ADDR_BITS-1:0] a,
		input kind_e                kind,
		input logic [ADDR_BITS:0]   limit
	);
		logic [ADDR_BITS:0] diff;
		logic [ADDR_BITS-1:0] res;
		diff = {1'b0, a} - limit;
		case (kind)
			KIND_SRAM:    res = {2'b00, a[14:0]};
			KIND_FLASH64: res = {1'b0, a[15:0]};
			default:      res = ({1'b0, a} >= limit) ? diff[ADDR_BITS-1:0] : a;
		endcase
		return res;
	endfunction

	// Number of bytes the chip kind addresses, capped at the store size.
	function automatic logic [ADDR_BITS:0] fsc_size(
		input kind_e              kind,
		input logic [ADDR_BITS:0] limit
	);
		logic [ADDR_BITS:0] s;
		case (kind)
			KIND_SRAM:    s = 18'd32768;
			KIND_FLASH64: s = 18'd65536;
			default:      s = 18'd131072;
		endcase
		return (s > limit) ? limit : s;
	endfunction

endpackage

// ===== sv/fsc_ram.sv =====
// ----------------------------------------------------------------------------
// fsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 131072,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/fsc_front.sv =====
// ----------------------------------------------------------------------------
// fsc_front
// Accepts bus items, runs the flash command sequence and queues store work.
// ----------------------------------------------------------------------------
module fsc_front
	import fsc_pkg::*;
#(
	parameter int STORE_BYTES = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  kind_e       chip_kind,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] offset,
	input  logic [7:0]  write_value,
	input  logic        q_full,
	input  logic        clearing,
	output logic        push,
	output q_entry_t    entry
);

	localparam logic [ADDR_BITS:0] STORE_SIZE = (ADDR_BITS+1)'(STORE_BYTES);

	stage_e unlock_q, unlock_d;
	stage_e erase_stage_q, erase_stage_d;
	logic   erase_pend_q, erase_pend_d;
	logic   prog_pend_q, prog_pend_d;
	logic   bank_pend_q, bank_pend_d;
	logic   id_mode_q, id_mode_d;
	logic   bank_q, bank_d;

	logic                 accept;
	logic                 is_flash;
	logic [ADDR_BITS-1:0] banked;
	logic                 at_a;
	logic                 at_b;

	assign in_stall = q_full || clearing;
	assign accept   = in_valid && !in_stall;
	assign is_flash = (chip_kind == KIND_FLASH64) || (chip_kind == KIND_FLASH128);
	assign banked   = {bank_q, offset};
	assign at_a     = (offset == ADDR_UNLOCK_A);
	assign at_b     = (offset == ADDR_UNLOCK_B);

	always_comb begin
		unlock_d      = unlock_q;
		erase_stage_d = erase_stage_q;
		erase_pend_d  = erase_pend_q;
		prog_pend_d   = prog_pend_q;
		bank_pend_d   = bank_pend_q;
		id_mode_d     = id_mode_q;
		bank_d        = bank_q;
		push          = 1'b0;
		entry.op      = OP_RD_CONST;
		entry.addr    = fsc_reduce(banked, chip_kind, STORE_SIZE);
		entry.data    = write_value;
		entry.kind    = chip_kind;
		if (accept && !action) begin
			push = 1'b1;
			if (chip_kind == KIND_SRAM) begin
				entry.op   = OP_RD_MEM;
				entry.addr = fsc_reduce({1'b0, offset}, chip_kind, STORE_SIZE);
			end else if (is_flash && id_mode_q && (offset[15:1] == 15'd0)) begin
				if (chip_kind == KIND_FLASH128) begin
					entry.data = offset[0] ? ID128_DEVICE : ID128_MAKER;
				end else begin
					entry.data = offset[0] ? ID64_DEVICE : ID64_MAKER;
				end
			end else if (is_flash) begin
				entry.op = OP_RD_MEM;
			end else begin
				entry.data = BYTE_ERASED;
			end
		end else if (accept && chip_kind == KIND_SRAM) begin
			push       = 1'b1;
			entry.op   = OP_WR_MEM;
			entry.addr = fsc_reduce({1'b0, offset}, chip_kind, STORE_SIZE);
		end else if (accept && is_flash) begin
			if (erase_pend_q) begin
				if (erase_stage_q == STAGE_IDLE && at_a && write_value == KEY_A) begin
					erase_stage_d = STAGE_ONE;
				end else if (erase_stage_q == STAGE_ONE && at_b && write_value == KEY_B) begin
					erase_stage_d = STAGE_TWO;
				end else if (erase_stage_q == STAGE_TWO) begin
					if (at_a && write_value == CMD_CHIP_ERS) begin
						push     = 1'b1;
						entry.op = OP_ERASE_CHIP;
					end else if (write_value == CMD_SECT_ERS) begin
						push       = 1'b1;
						entry.op   = OP_ERASE_SECT;
						entry.addr = {bank_q, offset[15:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
					end
					erase_pend_d  = 1'b0;
					erase_stage_d = STAGE_IDLE;
					unlock_d      = STAGE_IDLE;
				end
			end else if (prog_pend_q) begin
				push        = 1'b1;
				entry.op    = OP_PROG;
				prog_pend_d = 1'b0;
			end else if (bank_pend_q) begin
				if (offset == 16'd0) begin
					bank_d = write_value[0];
				end
				bank_pend_d = 1'b0;
			end else if (unlock_q == STAGE_IDLE && at_a && write_value == KEY_A) begin
				unlock_d = STAGE_ONE;
			end else if (unlock_q == STAGE_ONE && at_b && write_value == KEY_B) begin
				unlock_d = STAGE_TWO;
			end else if (unlock_q == STAGE_TWO && at_a) begin
				unlock_d = STAGE_IDLE;
				case (write_value)
					CMD_ID_ON:   id_mode_d    = 1'b1;
					CMD_ID_OFF:  id_mode_d    = 1'b0;
					CMD_ERASE:   erase_pend_d = 1'b1;
					CMD_PROGRAM: prog_pend_d  = 1'b1;
					CMD_BANK:    bank_pend_d  = 1'b1;
					default:     unlock_d     = STAGE_IDLE;
				endcase
			end else begin
				unlock_d = STAGE_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_q      <= STAGE_IDLE;
			erase_stage_q <= STAGE_IDLE;
			erase_pend_q  <= 1'b0;
			prog_pend_q   <= 1'b0;
			bank_pend_q   <= 1'b0;
			id_mode_q     <= 1'b0;
			bank_q        <= 1'b0;
		end else begin
			unlock_q      <= unlock_d;
			erase_stage_q <= erase_stage_d;
			erase_pend_q  <= erase_pend_d;
			prog_pend_q   <= prog_pend_d;
			bank_pend_q   <= bank_pend_d;
			id_mode_q     <= id_mode_d;
			bank_q        <= bank_d;
		end
	end

endmodule

// ===== sv/fsc_queue.sv =====
// ----------------------------------------------------------------------------
// fsc_queue
// Short first-in first-out queue of store operations.
// ----------------------------------------------------------------------------
module fsc_queue
	import fsc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	q_entry_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/fsc_back.sv =====
// ----------------------------------------------------------------------------
// fsc_back
// Carries out queued store operations against the save memory.
// ----------------------------------------------------------------------------
module fsc_back
	import fsc_pkg::*;
#(
	parameter int STORE_BYTES = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  q_entry_t    head,
	output logic        pop,
	output logic        clearing,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [ADDR_BITS:0] STORE_SIZE = (ADDR_BITS+1)'(STORE_BYTES);
	localparam logic [ADDR_BITS:0] STORE_LAST = STORE_SIZE - 1'b1;

	bk_state_e state_q, state_d;

	logic [ADDR_BITS-1:0]   sweep_q;
	logic [ADDR_BITS-1:0]   last_q;
	logic [SECTOR_BITS-1:0] sect_cnt_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [7:0]             data_q;
	kind_e                  kind_q;
	logic                   out_valid_q;
	logic [7:0]             read_data_q;

	logic                 out_free;
	logic                 out_load;
	logic [7:0]           out_data;
	logic                 latch_op;
	logic                 start_sweep;
	logic                 start_sect;
	logic                 step_sweep;
	logic                 step_sect;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [7:0]           wdata;
	logic [AW-1:0]        raddr;
	logic [7:0]           rdata;
	logic [ADDR_BITS:0]   chip_size_m1;
	logic [ADDR_BITS-1:0] sect_addr;

	assign out_free     = !out_valid_q || !out_stall;
	assign clearing     = (state_q == BK_CLEAR);
	assign chip_size_m1 = fsc_size(head.kind, STORE_SIZE) - 1'b1;
	assign sect_addr    = fsc_reduce(addr_q + ADDR_BITS'(sect_cnt_q), kind_q, STORE_SIZE);

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		out_load    = 1'b0;
		out_data    = head.data;
		latch_op    = 1'b0;
		start_sweep = 1'b0;
		start_sect  = 1'b0;
		step_sweep  = 1'b0;
		step_sect   = 1'b0;
		we          = 1'b0;
		waddr       = head.addr[AW-1:0];
		wdata       = head.data;
		raddr       = head.addr[AW-1:0];
		case (state_q)
			BK_CLEAR: begin
				we         = 1'b1;
				waddr      = sweep_q[AW-1:0];
				wdata      = BYTE_ERASED;
				step_sweep = 1'b1;
				if (sweep_q == STORE_LAST[ADDR_BITS-1:0]) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head_valid) begin
					case (head.op)
						OP_RD_MEM: begin
							if (out_free) begin
								pop     = 1'b1;
								state_d = BK_READ;
							end
						end
						OP_RD_CONST: begin
							if (out_free) begin
								pop      = 1'b1;
								out_load = 1'b1;
							end
						end
						OP_WR_MEM: begin
							pop = 1'b1;
							we  = 1'b1;
						end
						OP_PROG: begin
							pop      = 1'b1;
							latch_op = 1'b1;
							state_d  = BK_PROG;
						end
						OP_ERASE_CHIP: begin
							pop         = 1'b1;
							start_sweep = 1'b1;
							state_d     = BK_SWEEP;
						end
						OP_ERASE_SECT: begin
							pop        = 1'b1;
							latch_op   = 1'b1;
							start_sect = 1'b1;
							state_d    = BK_SECTOR;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			BK_READ: begin
				out_load = 1'b1;
				out_data = rdata;
				state_d  = BK_IDLE;
			end
			BK_PROG: begin
				we      = 1'b1;
				waddr   = addr_q[AW-1:0];
				wdata   = data_q & rdata;
				state_d = BK_IDLE;
			end
			BK_SWEEP: begin
				we         = 1'b1;
				waddr      = sweep_q[AW-1:0];
				wdata      = BYTE_ERASED;
				step_sweep = 1'b1;
				if (sweep_q == last_q) begin
					state_d = BK_IDLE;
				end
			end
			BK_SECTOR: begin
				we        = 1'b1;
				waddr     = sect_addr[AW-1:0];
				wdata     = BYTE_ERASED;
				step_sect = 1'b1;
				if (sect_cnt_q == {SECTOR_BITS{1'b1}}) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			sweep_q     <= '0;
			sect_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_sweep) begin
				sweep_q <= '0;
			end else if (step_sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (start_sect) begin
				sect_cnt_q <= '0;
			end else if (step_sect) begin
				sect_cnt_q <= sect_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_op) begin
			addr_q <= head.addr;
			data_q <= head.data;
			kind_q <= head.kind;
		end
		if (start_sweep) begin
			last_q <= chip_size_m1[ADDR_BITS-1:0];
		end
		if (out_load) begin
			read_data_q <= out_data;
		end
	end

	fsc_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

// ===== sv/flash_save_command_controller.sv =====
// ----------------------------------------------------------------------------
// flash_save_command_controller
// Cartridge save memory responder: SRAM store or command-driven flash.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   action, offset, write_value
//  out      output     out_valid / out_stall read_data
//  cfg      input      cfg_we                cfg_wdata (chip kind)
//
// A store read passes through BK_READ, a program write through BK_PROG.
// Chip erase writes one byte a cycle over the active size, sector erase 4096.
// After reset the whole store is cleared to 0xFF, with in_stall held high;
// a four-entry queue lets input run ahead of the store.
// A stalled result holds the output register; store reads wait for it.
module flash_save_command_controller
	import fsc_pkg::*;
#(
	parameter int STORE_BYTES = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] offset,
	input  logic [7:0]  write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	kind_e    chip_kind_q;
	logic     q_full;
	logic     clearing;
	logic     push;
	q_entry_t push_entry;
	logic     pop;
	logic     head_valid;
	q_entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_kind_q <= KIND_NONE;
		end else if (cfg_we) begin
			chip_kind_q <= kind_e'(cfg_wdata);
		end
	end

	fsc_front #(
		.STORE_BYTES (STORE_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.chip_kind   (chip_kind_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.offset      (offset),
		.write_value (write_value),
		.q_full      (q_full),
		.clearing    (clearing),
		.push        (push),
		.entry       (push_entry)
	);

	fsc_queue #(
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fsc_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data)
	);

endmodule

// ===== sv/fsc_checker.sv =====
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the save controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data
);

	// The store is being cleared right after reset, so no item can enter.
	`ASSERT_IMPLIES(a_clear_after_reset, clk, arst_n, $past(arst_n) == 1'b0, in_stall)
	// No result can exist before any item was accepted after reset.
	`ASSERT_IMPLIES(a_no_early_result, clk, arst_n, $past(arst_n) == 1'b0, !out_valid)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(read_data))

endmodule

bind flash_save_command_controller fsc_checker u_fsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data)
);
